// ===== hdl/lcdns_pkg.sv =====
// Shared types, constants and pin-pattern functions for the LCD nibble sequencer.
`default_nettype none
package lcdns_pkg;

	typedef enum logic [1:0] {
		OP_INIT   = 2'd0,
		OP_INSTR  = 2'd1,
		OP_CHAR   = 2'd2,
		OP_CURSOR = 2'd3
	} op_kind_t;

	// One classified request as it travels from the front to the sequencer.
	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  data_byte;
	} op_t;

	// One pin state.
	typedef struct packed {
		logic [3:0]  nib;
		logic        rs;
		logic        en;
		logic [15:0] hold;
		logic        last;
	} res_t;

	localparam int unsigned OPQ_DEPTH = 2;
	localparam int unsigned OUTQ_DEPTH = 2;

	localparam logic [7:0]  DDRAM_SET = 8'h80;
	localparam logic [3:0]  NIB_SYNC = 4'h3;
	localparam logic [3:0]  NIB_BUS4 = 4'h2;

	localparam logic [15:0] HOLD_STROBE    = 16'd1;
	localparam logic [15:0] HOLD_SETTLE    = 16'd70;
	localparam logic [15:0] HOLD_CHAR_TAIL = 16'd46;
	localparam logic [15:0] HOLD_CMD       = 16'd53;
	localparam logic [15:0] HOLD_CLEAR     = 16'd3000;
	localparam logic [15:0] HOLD_SYNC      = 16'd4500;
	localparam logic [15:0] HOLD_SYNC_LAST = 16'd150;
	localparam logic [15:0] HOLD_POWERUP   = 16'hFFFF;

	// Init run groups.
	localparam logic [3:0] GRP_PWR       = 4'd0;
	localparam logic [3:0] GRP_SYNC_LAST = 4'd3;
	localparam logic [3:0] GRP_BUS4      = 4'd4;
	localparam logic [3:0] GRP_BYTE0     = 4'd5;
	localparam logic [3:0] GRP_BYTE_LAST = 4'd9;

	// Phases within a pulse / byte.
	localparam logic [2:0] PH_PULSE_END = 3'd2;
	localparam logic [2:0] PH_SYNC_WAIT = 3'd3;
	localparam logic [2:0] PH_CHAR_END  = 3'd3;
	localparam logic [2:0] PH_INSTR_END = 3'd5;
	localparam logic [2:0] PH_BYTE_WAIT = 3'd6;

	function automatic logic [7:0] init_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = 8'h28;
			3'd1:    b = 8'h08;
			3'd2:    b = 8'h01;
			3'd3:    b = 8'h06;
			default: b = 8'h0D;
		endcase
		return b;
	endfunction

	function automatic logic [15:0] init_hold(input logic [2:0] idx);
		logic [15:0] h;
		unique case (idx)
			3'd2, 3'd3: h = HOLD_CLEAR;
			default:    h = HOLD_CMD;
		endcase
		return h;
	endfunction

	// Three-step enable pulse: low 1us, high 1us, low 70us.
	function automatic res_t pulse_step(input logic [3:0] nib, input logic rs,
			input logic [1:0] ph);
		res_t r;
		r.nib  = nib;
		r.rs   = rs;
		r.en   = (ph == 2'd1);
		r.hold = (ph == 2'd2) ? HOLD_SETTLE : HOLD_STROBE;
		r.last = 1'b0;
		return r;
	endfunction

	// Instruction byte: high pulse, low pulse, then a wait on the low nibble.
	function automatic res_t byte_step(input logic [7:0] b, input logic [2:0] ph,
			input logic [15:0] tail_hold);
		res_t r;
		logic [2:0] sub;
		sub = (ph > PH_PULSE_END) ? 3'(ph - 3'd3) : ph;
		if (ph == PH_BYTE_WAIT) begin
			r.nib  = b[3:0];
			r.rs   = 1'b0;
			r.en   = 1'b0;
			r.hold = tail_hold;
			r.last = 1'b0;
		end else begin
			r = pulse_step((ph > PH_PULSE_END) ? b[3:0] : b[7:4], 1'b0, sub[1:0]);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/char_lcd_nibble_sequencer.sv =====
// Top level of the character LCD nibble sequencer (4-bit bus pin-state generator).
//
//  channel   handshake      fields
//  --------  -------------  ------------------------------------------------------
//  request   push / full    command, byte_value, row, column
//  result    pop / empty    data_nibble, register_select, enable, hold_us, last
//
// One pin state leaves the sequencer per cycle while the result queue has room;
// each request kind walks its own run of states, set by the step counters. A
// two-entry request queue lets the next request in while the current one still
// runs, and a two-entry result queue keeps the sequencer going while a result
// waits. A push is registered in the request queue and its first result in the
// result queue. Reset clears only queue pointers, fill counts and step counters.
`default_nettype none
module char_lcd_nibble_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request side
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  byte_value,
	input  wire logic        row,
	input  wire logic [3:0]  column,
	// result side
	output logic             empty,
	input  wire logic        pop,
	output logic [3:0]       data_nibble,
	output logic             register_select,
	output logic             enable,
	output logic [15:0]      hold_us,
	output logic             last
);
	import lcdns_pkg::*;

	logic  op_valid;
	op_t   op;
	logic  op_pop;
	logic  res_valid;
	logic  res_ready;
	res_t  res;
	res_t  head;

	// Front: classify and queue requests.
	lcdns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.byte_value (byte_value),
		.row        (row),
		.column     (column),
		.op_valid   (op_valid),
		.op         (op),
		.op_pop     (op_pop)
	);

	// Back: walk the pin states of the request at the queue head.
	lcdns_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.op_pop    (op_pop),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	// Results wait here until popped.
	lcdns_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_valid),
		.wr_data  (res),
		.wr_ready (res_ready),
		.pop      (pop),
		.empty    (empty),
		.rd_data  (head)
	);

	assign data_nibble     = head.nib;
	assign register_select = head.rs;
	assign enable          = head.en;
	assign hold_us         = head.hold;
	assign last            = head.last;

endmodule
`default_nettype wire

// ===== hdl/lcdns_front.sv =====
// Front end: accepts requests, classifies them and queues them for the sequencer.
`default_nettype none
module lcdns_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [1:0]        command,
	input  wire logic [7:0]        byte_value,
	input  wire logic              row,
	input  wire logic [3:0]        column,
	output logic                   op_valid,
	output lcdns_pkg::op_t         op,
	input  wire logic              op_pop
);
	import lcdns_pkg::*;

	localparam int unsigned PW = $clog2(OPQ_DEPTH);
	localparam int unsigned CW = $clog2(OPQ_DEPTH + 1);

	op_t           mem_q [OPQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	op_t           op_in;
	logic          wr_fire;
	logic          rd_fire;

	// Classify: cursor moves become their address byte up front.
	always_comb begin
		op_in.kind = op_kind_t'(command);
		if (op_in.kind == OP_CURSOR) begin
			op_in.data_byte = DDRAM_SET | {1'b0, row, 2'b00, column};
		end else begin
			op_in.data_byte = byte_value;
		end
	end

	assign full     = (cnt_q == CW'(OPQ_DEPTH));
	assign op_valid = (cnt_q != '0);
	assign op       = mem_q[rd_ptr_q];
	assign wr_fire  = push && !full;
	assign rd_fire  = op_pop && op_valid;

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == PW'(OPQ_DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == PW'(OPQ_DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (wr_fire && !rd_fire) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (rd_fire && !wr_fire) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lcdns_seq.sv =====
// Back end: steps through the pin states of one queued request, one per cycle while the result queue has room.
`default_nettype none
module lcdns_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              op_valid,
	input  wire lcdns_pkg::op_t    op,
	output logic                   op_pop,
	input  wire logic              res_ready,
	output logic                   res_valid,
	output lcdns_pkg::res_t        res
);
	import lcdns_pkg::*;

	logic [3:0] grp_q;
	logic [2:0] ph_q;
	logic       grp_end;
	logic       run_end;
	logic [2:0] init_idx;
	res_t       r;
	logic       step;

	assign init_idx = 3'(grp_q - GRP_BYTE0);

	always_comb begin
		r       = '0;
		grp_end = 1'b0;
		run_end = 1'b0;
		unique case (op.kind)
			OP_INIT: begin
				if (grp_q == GRP_PWR) begin
					r.hold  = HOLD_POWERUP;
					grp_end = 1'b1;
				end else if (grp_q <= GRP_SYNC_LAST) begin
					if (ph_q == PH_SYNC_WAIT) begin
						r.nib  = NIB_SYNC;
						r.hold = (grp_q == GRP_SYNC_LAST) ? HOLD_SYNC_LAST : HOLD_SYNC;
					end else begin
						r = pulse_step(NIB_SYNC, 1'b0, ph_q[1:0]);
					end
					grp_end = (ph_q == PH_SYNC_WAIT);
				end else if (grp_q == GRP_BUS4) begin
					r       = pulse_step(NIB_BUS4, 1'b0, ph_q[1:0]);
					grp_end = (ph_q == PH_PULSE_END);
				end else begin
					r       = byte_step(init_byte(init_idx), ph_q, init_hold(init_idx));
					grp_end = (ph_q == PH_BYTE_WAIT);
					run_end = grp_end && (grp_q == GRP_BYTE_LAST);
				end
			end
			OP_INSTR: begin
				r       = byte_step(op.data_byte, ph_q, HOLD_CMD);
				run_end = (ph_q == PH_INSTR_END);
			end
			OP_CHAR: begin
				r.nib   = (ph_q[1]) ? op.data_byte[3:0] : op.data_byte[7:4];
				r.rs    = 1'b1;
				r.en    = !ph_q[0];
				r.hold  = (ph_q == PH_CHAR_END) ? HOLD_CHAR_TAIL : HOLD_STROBE;
				run_end = (ph_q == PH_CHAR_END);
			end
			OP_CURSOR: begin
				r       = byte_step(op.data_byte, ph_q, HOLD_CMD);
				run_end = (ph_q == PH_BYTE_WAIT);
			end
		endcase
		r.last = run_end;
	end

	assign step      = op_valid && res_ready;
	assign res_valid = op_valid;
	assign res       = r;
	assign op_pop    = step && run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
			ph_q  <= '0;
		end else if (step) begin
			if (run_end) begin
				grp_q <= '0;
				ph_q  <= '0;
			end else if (grp_end) begin
				grp_q <= 4'(grp_q + 1'b1);
				ph_q  <= '0;
			end else begin
				ph_q <= 3'(ph_q + 1'b1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lcdns_outq.sv =====
// Result queue between the sequencer and the output ports.
`default_nettype none
module lcdns_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire lcdns_pkg::res_t   wr_data,
	output logic                   wr_ready,
	input  wire logic              pop,
	output logic                   empty,
	output lcdns_pkg::res_t        rd_data
);
	import lcdns_pkg::*;

	localparam int unsigned PW = $clog2(OUTQ_DEPTH);
	localparam int unsigned CW = $clog2(OUTQ_DEPTH + 1);

	res_t          mem_q [OUTQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          wr_fire;
	logic          rd_fire;

	assign empty    = (cnt_q == '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign rd_fire  = pop && !empty;
	// A slot frees up in the same cycle the consumer pops.
	assign wr_ready = (cnt_q != CW'(OUTQ_DEPTH)) || rd_fire;
	assign wr_fire  = wr_en && wr_ready;

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == PW'(OUTQ_DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == PW'(OUTQ_DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (wr_fire && !rd_fire) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (rd_fire && !wr_fire) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

endmodule
`default_nettype wire
